// File: rtl/core/sorted_range_count_top_macros.svh
// Assertion macros shared by the sorted range count RTL.
`ifndef SORTED_RANGE_COUNT_TOP_MACROS_SVH
`define SORTED_RANGE_COUNT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/src_pkg.sv
// Shared types and constants for the sorted range count block.
`timescale 1ns / 1ps

package src_pkg;

  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int REQ_W   = 2;
  localparam int COUNT_W = 11;
  localparam int OUT_DW  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // Request codes carried in in_tuser
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Search command from the control FSM
  typedef struct packed {
    logic start;
    logic upper;   // 1: upper bound (entry <= key), 0: lower bound (entry < key)
  } srch_cmd_t;

  // Search status back to the control FSM
  typedef struct packed {
    logic busy;
    logic done;
  } srch_rsp_t;

endpackage

// File: rtl/core/src_search.sv
// Value store memory and the bisection sequencer that searches it.
`timescale 1ns / 1ps
`include "sorted_range_count_top_macros.svh"

module src_search #(
  parameter int STORE_DEPTH = src_pkg::DEF_STORE_DEPTH,
  parameter int VALUE_WIDTH = src_pkg::DEF_VALUE_WIDTH,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  src_pkg::srch_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [CW-1:0]          count,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  output src_pkg::srch_rsp_t     rsp,
  output logic [CW-1:0]          pos
);
  import src_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} srch_state_t;

  logic [VALUE_WIDTH-1:0] mem [STORE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]          rd_addr;

  srch_state_t            state_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic                   upper_r;
  logic [CW-1:0]          lo_r, hi_r, mid_r, pos_r;
  logic                   done_r;

  logic                   go_right;
  logic [CW-1:0]          lo_nxt, hi_nxt, mid_nxt, half_count;
  logic [CW:0]            sum_n;
  logic                   more;

  // rd_data_r holds mem[mid_r] while running
  always_comb begin
    if (upper_r) begin
      go_right = $signed(rd_data_r) <= $signed(key_r);
    end else begin
      go_right = $signed(rd_data_r) < $signed(key_r);
    end
    lo_nxt     = go_right ? (mid_r + 1'b1) : lo_r;
    hi_nxt     = go_right ? hi_r : mid_r;
    sum_n      = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt    = sum_n[CW:1];
    more       = lo_nxt < hi_nxt;
    half_count = count >> 1;
    // every mid that is used lies below count, so it fits the address width
    rd_addr    = (state_r == S_IDLE) ? half_count[AW-1:0] : mid_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            key_r   <= key;
            upper_r <= cmd.upper;
            if (count == '0) begin
              done_r <= 1'b1;
              pos_r  <= '0;
            end else begin
              lo_r    <= '0;
              hi_r    <= count;
              mid_r   <= half_count;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (more) begin
            lo_r  <= lo_nxt;
            hi_r  <= hi_nxt;
            mid_r <= mid_nxt;
          end else begin
            done_r  <= 1'b1;
            pos_r   <= lo_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r == S_RUN);
  assign rsp.done = done_r;
  assign pos      = pos_r;

  `SRC_CHECK(a_run_window, state_r == S_RUN, lo_r < hi_r, "search window empty while running")
  `SRC_CHECK(a_mid_inside, state_r == S_RUN, mid_r >= lo_r && mid_r < hi_r, "probe off window")
  `SRC_CHECK(a_done_idle, done_r, state_r == S_IDLE, "done raised while still searching")

endmodule

// File: rtl/core/sorted_range_count_top.sv
// Top level of the sorted range count block: request decode, count and result register.
// Channel | Dir | Ports                          | Transfer carries
// in_     | in  | in_tvalid/in_tready/in_tdata/in_tuser | request kind, value, bounds
// out_    | out | out_tvalid/out_tready/out_tdata/out_tuser | match count, overflow flag
// Clear and unused request codes give no result.
// Append: the result goes via T_EMIT to the output register; in_tready is low meanwhile.
// Query: one store read per bisection step, lower bound first, then upper bound.
// Reset (rst_n low, synchronous) empties the store; no clearing pass is needed.
// in_tready is high only while idle; a result held by out_tready stalls the block
// only once the following result is ready to leave.
`timescale 1ns / 1ps
`include "sorted_range_count_top_macros.svh"

module sorted_range_count_top #(
  parameter int STORE_DEPTH = src_pkg::DEF_STORE_DEPTH,
  parameter int VALUE_WIDTH = src_pkg::DEF_VALUE_WIDTH,
  localparam int IN_DW = ((3 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DW-1:0]          in_tdata,   // value, range_low, range_high
  input  logic [src_pkg::REQ_W-1:0] in_tuser,   // req_type
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [src_pkg::OUT_DW-1:0] out_tdata, // match_count
  output logic                      out_tuser   // overflow
);
  import src_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [1:0] {T_IDLE, T_LO, T_HI, T_EMIT} ctl_state_t;

  ctl_state_t             state_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          down_r;
  logic [VALUE_WIDTH-1:0] hi_key_r;
  logic [COUNT_W-1:0]     res_cnt_r, out_cnt_r;
  logic                   res_ovf_r, out_ovf_r, out_valid_r;

  logic                   accept, full, slot_free;
  logic [REQ_W-1:0]       req;
  logic [VALUE_WIDTH-1:0] in_value, in_low, in_high, srch_key;
  srch_cmd_t              cmd;
  srch_rsp_t              rsp;
  logic [CW-1:0]          pos, diff;
  logic [31:0]            diff_wide;
  logic [COUNT_W-1:0]     count_sat;

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign req       = in_tuser;
  assign in_value  = in_tdata[VALUE_WIDTH-1:0];
  assign in_low    = in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign in_high   = in_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH];
  assign full      = (cnt_r == CW'(STORE_DEPTH));
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    cmd.start = (accept && (req == REQ_QUERY)) || ((state_r == T_LO) && rsp.done);
    cmd.upper = (state_r == T_LO);
    srch_key  = (state_r == T_LO) ? hi_key_r : in_low;
    diff      = (pos > down_r) ? (pos - down_r) : '0;
    diff_wide = 32'(diff);
    count_sat = (diff_wide > 32'(COUNT_MAX)) ? COUNT_MAX : diff_wide[COUNT_W-1:0];
  end

  src_search #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .key     (srch_key),
    .count   (cnt_r),
    .wr_en   (accept && (req == REQ_APPEND) && !full),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_value),
    .rsp     (rsp),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == T_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            unique case (req)
              REQ_CLEAR: cnt_r <= '0;
              REQ_APPEND: begin
                res_cnt_r <= '0;
                res_ovf_r <= full;
                if (!full) begin
                  cnt_r <= cnt_r + 1'b1;
                end
                state_r <= T_EMIT;
              end
              REQ_QUERY: begin
                hi_key_r <= in_high;
                state_r  <= T_LO;
              end
              default: ;
            endcase
          end
        end
        T_LO: begin
          if (rsp.done) begin
            down_r  <= pos;
            state_r <= T_HI;
          end
        end
        T_HI: begin
          if (rsp.done) begin
            res_cnt_r <= count_sat;
            res_ovf_r <= 1'b0;
            state_r   <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (slot_free) begin
            out_cnt_r   <= res_cnt_r;
            out_ovf_r   <= res_ovf_r;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - COUNT_W){1'b0}}, out_cnt_r};
  assign out_tuser  = out_ovf_r;

  `SRC_CHECK(a_start_free, cmd.start, !rsp.busy, "search started while busy")
  `SRC_CHECK(a_done_state, rsp.done, (state_r == T_LO) || (state_r == T_HI), "stray search done")
  `SRC_CHECK_NEXT(a_clear_count, accept && (req == REQ_CLEAR), cnt_r == '0, "clear kept count")
  `SRC_CHECK(a_count_bound, 1'b1, cnt_r <= CW'(STORE_DEPTH), "count beyond store depth")

endmodule
